// ----- rtl/wpl3d_pkg.sv -----
// shared constants, types and helper functions of the wrapped phase laplacian
package wpl3d_pkg;

  localparam int MAX_X = 64;
  localparam int MAX_Y = 64;
  localparam int MAX_Z = 64;
  localparam int PHASE_W = 16;

  localparam int MAX_DIM = (MAX_X > MAX_Y) ? ((MAX_X > MAX_Z) ? MAX_X : MAX_Z)
                                           : ((MAX_Y > MAX_Z) ? MAX_Y : MAX_Z);

  // field widths of the ports
  localparam int SIZE_W    = 7;
  localparam int WEIGHT_W  = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int LAP_W     = 31;
  localparam int MIN_SIZE  = 3;

  localparam int COORD_W = $clog2(MAX_DIM);
  localparam int PLANE_W = $clog2(MAX_X * MAX_Y + 1);
  localparam int TOT_W   = $clog2(MAX_X * MAX_Y * MAX_Z + 1);

  // line store segments: plane minus one row, and one row minus one voxel
  localparam int SEG_LONG_DEPTH  = MAX_X * (MAX_Y - 1);
  localparam int SEG_LONG_AW     = $clog2(SEG_LONG_DEPTH);
  localparam int SEG_SHORT_DEPTH = MAX_X - 1;
  localparam int SEG_SHORT_AW    = $clog2(SEG_SHORT_DEPTH);

  // arithmetic widths
  localparam int PROD_W = PHASE_W + WEIGHT_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam int MAG_W  = PROD_W;
  localparam int LO_W   = 17;
  localparam int HI_W   = MAG_W - LO_W;
  localparam int QHI_W  = HI_W - 2;
  localparam int REM_W  = LO_W + 3;

  // divide by 7 as multiply by reciprocal, exact over the operand ranges
  localparam int DIV_HI_K_W = 17;
  localparam int DIV_HI_K   = 74899;
  localparam int DIV_HI_SH  = 19;
  localparam int HI_PROD_W  = HI_W + DIV_HI_K_W;
  localparam int DIV_LO_K_W = 21;
  localparam int DIV_LO_K   = 1198373;
  localparam int DIV_LO_SH  = 23;
  localparam int LO_PROD_W  = REM_W + DIV_LO_K_W;

  localparam int RES_DEPTH = 8;
  localparam int RES_AW    = $clog2(RES_DEPTH);
  localparam int PEND_W    = $clog2(RES_DEPTH + 4);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X,
    REG_SIZE_Y,
    REG_SIZE_Z,
    REG_INV_SQ_X,
    REG_INV_SQ_Y,
    REG_INV_SQ_Z
  } cfg_reg_t;

  typedef struct packed {
    logic                    advance;
    logic                    clear;
    logic [SEG_LONG_AW-1:0]  long_len;
    logic [SEG_SHORT_AW-1:0] short_len;
  } win_ctrl_t;

  typedef struct packed {
    logic [PHASE_W-1:0] z_fwd;
    logic [PHASE_W-1:0] y_fwd;
    logic [PHASE_W-1:0] x_fwd;
    logic [PHASE_W-1:0] centre;
    logic [PHASE_W-1:0] x_back;
    logic [PHASE_W-1:0] y_back;
    logic [PHASE_W-1:0] z_back;
  } win_taps_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                   input logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] r;
    if (v < CFG_W'(MIN_SIZE)) begin
      r = SIZE_W'(MIN_SIZE);
    end else if (v > CFG_W'(hi)) begin
      r = hi;
    end else begin
      r = SIZE_W'(v);
    end
    return r;
  endfunction

  // fwd + back - 2*centre, wrapped into the signed phase range
  function automatic logic signed [PHASE_W-1:0] wrap_diff(input logic [PHASE_W-1:0] f,
                                                          input logic [PHASE_W-1:0] b,
                                                          input logic [PHASE_W-1:0] c);
    logic [PHASE_W-1:0] d;
    d = f + b - {c[PHASE_W-2:0], 1'b0};
    return $signed(d);
  endfunction

endpackage

// ----- rtl/wpl3d_if.sv -----
// valid/ready channels for voxel beats and result beats
interface wpl3d_in_if import wpl3d_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [PHASE_W-1:0] phase;
  logic                      flush;

  modport source (output valid, output phase, output flush, input ready);
  modport sink (input valid, input phase, input flush, output ready);
endinterface

interface wpl3d_out_if import wpl3d_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [LAP_W-1:0] laplacian;
  logic                    last_voxel;

  modport source (output valid, output laplacian, output last_voxel, input ready);
  modport sink (input valid, input laplacian, input last_voxel, output ready);
endinterface

// ----- rtl/wpl3d_ram.sv -----
// generic simple dual port ram with registered read
module wpl3d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/wpl3d_window.sv -----
// line store: chain of delay segments giving the seven-point window
module wpl3d_window import wpl3d_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  win_ctrl_t          ctrl,
  input  logic [PHASE_W-1:0] head,
  output win_taps_t          taps
);

  logic [SEG_LONG_AW-1:0]  ptr_long;
  logic [SEG_LONG_AW-1:0]  ptr_long_next;
  logic [SEG_SHORT_AW-1:0] ptr_short;
  logic [SEG_SHORT_AW-1:0] ptr_short_next;
  logic [PHASE_W-1:0]      a_rd;
  logic [PHASE_W-1:0]      b_rd;
  logic [PHASE_W-1:0]      c_rd;
  logic [PHASE_W-1:0]      d_rd;
  logic [PHASE_W-1:0]      centre;
  logic [PHASE_W-1:0]      back;

  // read runs one step ahead so the oldest entry is ready when the window moves
  always_comb begin
    ptr_long_next  = ptr_long;
    ptr_short_next = ptr_short;
    if (ctrl.clear) begin
      ptr_long_next  = '0;
      ptr_short_next = '0;
    end else if (ctrl.advance) begin
      if (ptr_long == ctrl.long_len - SEG_LONG_AW'(1)) begin
        ptr_long_next = '0;
      end else begin
        ptr_long_next = ptr_long + SEG_LONG_AW'(1);
      end
      if (ptr_short == ctrl.short_len - SEG_SHORT_AW'(1)) begin
        ptr_short_next = '0;
      end else begin
        ptr_short_next = ptr_short + SEG_SHORT_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr_long  <= '0;
      ptr_short <= '0;
    end else begin
      ptr_long  <= ptr_long_next;
      ptr_short <= ptr_short_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      centre <= b_rd;
      back   <= centre;
    end
  end

  wpl3d_ram #(.WIDTH(PHASE_W), .DEPTH(SEG_LONG_DEPTH)) u_seg_a (
    .clk   (clk),
    .we    (ctrl.advance),
    .waddr (ptr_long),
    .wdata (head),
    .raddr (ptr_long_next),
    .rdata (a_rd)
  );

  wpl3d_ram #(.WIDTH(PHASE_W), .DEPTH(SEG_SHORT_DEPTH)) u_seg_b (
    .clk   (clk),
    .we    (ctrl.advance),
    .waddr (ptr_short),
    .wdata (a_rd),
    .raddr (ptr_short_next),
    .rdata (b_rd)
  );

  wpl3d_ram #(.WIDTH(PHASE_W), .DEPTH(SEG_SHORT_DEPTH)) u_seg_c (
    .clk   (clk),
    .we    (ctrl.advance),
    .waddr (ptr_short),
    .wdata (back),
    .raddr (ptr_short_next),
    .rdata (c_rd)
  );

  wpl3d_ram #(.WIDTH(PHASE_W), .DEPTH(SEG_LONG_DEPTH)) u_seg_d (
    .clk   (clk),
    .we    (ctrl.advance),
    .waddr (ptr_long),
    .wdata (c_rd),
    .raddr (ptr_long_next),
    .rdata (d_rd)
  );

  assign taps.z_fwd  = head;
  assign taps.y_fwd  = a_rd;
  assign taps.x_fwd  = b_rd;
  assign taps.centre = centre;
  assign taps.x_back = back;
  assign taps.y_back = c_rd;
  assign taps.z_back = d_rd;

endmodule

// ----- rtl/wrapped_phase_laplacian_3d_core.sv -----
// streaming wrapped phase laplacian over a raster-order 3-d volume
// one beat per clock in and out unless voxel ready drops (result queue plus pipeline full) or
// result ready is low; a result passes input, product and divide registers into the result queue
// a result is released one plane plus one voxel behind the stream; flush beats drain
// reset: sizes 64, weights 1.0 (4096), positions zero; line store needs no clearing
module wrapped_phase_laplacian_3d_core import wpl3d_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  wpl3d_in_if.sink             voxel,
  wpl3d_out_if.source          result,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  typedef struct packed {
    logic signed [LAP_W-1:0] laplacian;
    logic                    last_voxel;
  } res_t;

  logic [SIZE_W-1:0]   sx;
  logic [SIZE_W-1:0]   sy;
  logic [SIZE_W-1:0]   sz;
  logic [WEIGHT_W-1:0] wx;
  logic [WEIGHT_W-1:0] wy;
  logic [WEIGHT_W-1:0] wz;
  logic [PLANE_W-1:0]  plane;
  logic [TOT_W-1:0]    total;

  logic [TOT_W-1:0]    in_pos;
  logic [TOT_W-1:0]    in_pos_next;
  logic [TOT_W-1:0]    out_pos;
  logic [COORD_W-1:0]  ox;
  logic [COORD_W-1:0]  oy;
  logic [COORD_W-1:0]  oz;
  logic                x_end;
  logic                y_end;
  logic                z_end;

  logic                accept;
  logic                s0_valid;
  logic                s0_flush;
  logic [PHASE_W-1:0]  s0_phase;
  logic                wr;
  logic                emit;
  logic                last;
  logic                size_wr;

  win_ctrl_t           win_ctrl;
  win_taps_t           taps;
  logic [PHASE_W-1:0]  xf;
  logic [PHASE_W-1:0]  xb;
  logic [PHASE_W-1:0]  yf;
  logic [PHASE_W-1:0]  yb;
  logic [PHASE_W-1:0]  zf;
  logic [PHASE_W-1:0]  zb;
  logic signed [PHASE_W-1:0] dx;
  logic signed [PHASE_W-1:0] dy;
  logic signed [PHASE_W-1:0] dz;
  logic signed [PROD_W-1:0]  prod_x;
  logic signed [PROD_W-1:0]  prod_y;
  logic signed [PROD_W-1:0]  prod_z;

  logic                      p_valid;
  logic                      p_last;
  logic signed [PROD_W-1:0]  p_x;
  logic signed [PROD_W-1:0]  p_y;
  logic signed [PROD_W-1:0]  p_z;

  logic signed [SUM_W-1:0]   sum;
  logic [MAG_W-1:0]          mag;
  logic [HI_PROD_W-1:0]      hi_prod;

  logic                      d_valid;
  logic                      d_last;
  logic                      d_neg;
  logic [HI_W-1:0]           d_hi;
  logic [QHI_W-1:0]          d_qhi;
  logic [LO_W-1:0]           d_lo;

  logic [2:0]                r_hi;
  logic [REM_W-1:0]          rem;
  logic [LO_PROD_W-1:0]      lo_prod;
  logic [LO_W-1:0]           q_lo;
  logic [LAP_W-1:0]          q_mag;
  res_t                      res_new;

  res_t                      res_mem [RES_DEPTH];
  logic [RES_AW-1:0]         wr_ptr;
  logic [RES_AW-1:0]         rd_ptr;
  logic [RES_AW:0]           res_count;
  logic                      pop;
  logic [PEND_W-1:0]         pending;

  // ---------------------------------------------------------------- config
  assign size_wr = cfg_wr_en &&
                   (cfg_index inside {REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z});

  always_ff @(posedge clk) begin
    if (rst) begin
      sx <= SIZE_W'(MAX_X);
      sy <= SIZE_W'(MAX_Y);
      sz <= SIZE_W'(MAX_Z);
      wx <= WEIGHT_W'(4096);
      wy <= WEIGHT_W'(4096);
      wz <= WEIGHT_W'(4096);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SIZE_X:   sx <= clamp_size(cfg_data, SIZE_W'(MAX_X));
        REG_SIZE_Y:   sy <= clamp_size(cfg_data, SIZE_W'(MAX_Y));
        REG_SIZE_Z:   sz <= clamp_size(cfg_data, SIZE_W'(MAX_Z));
        REG_INV_SQ_X: wx <= cfg_data;
        REG_INV_SQ_Y: wy <= cfg_data;
        REG_INV_SQ_Z: wz <= cfg_data;
        default: ;
      endcase
    end
  end

  assign plane = PLANE_W'(sx) * PLANE_W'(sy);
  assign total = TOT_W'(plane) * TOT_W'(sz);

  // ---------------------------------------------------------------- input stage
  assign pending = PEND_W'(res_count) + PEND_W'(s0_valid) + PEND_W'(p_valid) +
                   PEND_W'(d_valid);
  assign voxel.ready = pending < PEND_W'(RES_DEPTH);
  assign accept = voxel.valid && voxel.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_phase <= voxel.phase;
      s0_flush <= voxel.flush;
    end
  end

  // ---------------------------------------------------------------- positions
  assign wr          = s0_valid && !s0_flush && (in_pos < total);
  assign in_pos_next = in_pos + TOT_W'(wr);
  assign emit        = s0_valid && (out_pos < total) &&
                       ((in_pos_next > out_pos + TOT_W'(plane)) || (in_pos_next >= total));
  assign last        = (out_pos + TOT_W'(1)) == total;

  assign x_end = SIZE_W'(ox) == sx - SIZE_W'(1);
  assign y_end = SIZE_W'(oy) == sy - SIZE_W'(1);
  assign z_end = SIZE_W'(oz) == sz - SIZE_W'(1);

  always_ff @(posedge clk) begin
    if (rst || size_wr) begin
      in_pos  <= '0;
      out_pos <= '0;
      ox      <= '0;
      oy      <= '0;
      oz      <= '0;
    end else if (emit && last) begin
      in_pos  <= '0;
      out_pos <= '0;
      ox      <= '0;
      oy      <= '0;
      oz      <= '0;
    end else begin
      in_pos <= in_pos_next;
      if (emit) begin
        out_pos <= out_pos + TOT_W'(1);
        if (x_end) begin
          ox <= '0;
          if (y_end) begin
            oy <= '0;
            oz <= oz + COORD_W'(1);
          end else begin
            oy <= oy + COORD_W'(1);
          end
        end else begin
          ox <= ox + COORD_W'(1);
        end
      end
    end
  end

  // ---------------------------------------------------------------- window
  // the window moves on each beat that stores a voxel or emits a result
  assign win_ctrl.advance   = wr || emit;
  assign win_ctrl.clear     = size_wr;
  assign win_ctrl.long_len  = SEG_LONG_AW'(plane - PLANE_W'(sx));
  assign win_ctrl.short_len = SEG_SHORT_AW'(sx - SIZE_W'(1));

  wpl3d_window u_window (
    .clk  (clk),
    .rst  (rst),
    .ctrl (win_ctrl),
    .head (s0_phase),
    .taps (taps)
  );

  // edges replicate the centre voxel
  assign xf = x_end       ? taps.centre : taps.x_fwd;
  assign xb = (ox == '0)  ? taps.centre : taps.x_back;
  assign yf = y_end       ? taps.centre : taps.y_fwd;
  assign yb = (oy == '0)  ? taps.centre : taps.y_back;
  assign zf = z_end       ? taps.centre : taps.z_fwd;
  assign zb = (oz == '0)  ? taps.centre : taps.z_back;

  assign dx = wrap_diff(xf, xb, taps.centre);
  assign dy = wrap_diff(yf, yb, taps.centre);
  assign dz = wrap_diff(zf, zb, taps.centre);

  assign prod_x = dx * $signed({1'b0, wx});
  assign prod_y = dy * $signed({1'b0, wy});
  assign prod_z = dz * $signed({1'b0, wz});

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    p_last <= last;
    p_x    <= prod_x;
    p_y    <= prod_y;
    p_z    <= prod_z;
  end

  // ---------------------------------------------------------------- divide by 7
  // magnitude split as hi*2^17 + lo; hi/7 here, remainder folded in next stage
  assign sum     = SUM_W'(p_x) + SUM_W'(p_y) + SUM_W'(p_z);
  assign mag     = sum[SUM_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
  assign hi_prod = HI_PROD_W'(mag[MAG_W-1:LO_W]) * HI_PROD_W'(DIV_HI_K);

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else begin
      d_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    d_last <= p_last;
    d_neg  <= sum[SUM_W-1];
    d_hi   <= mag[MAG_W-1:LO_W];
    d_qhi  <= hi_prod[DIV_HI_SH +: QHI_W];
    d_lo   <= mag[LO_W-1:0];
  end

  // hi - 7*q equals hi + q modulo 8, and the remainder is below 7
  assign r_hi    = d_hi[2:0] + d_qhi[2:0];
  assign rem     = {r_hi, d_lo};
  assign lo_prod = LO_PROD_W'(rem) * LO_PROD_W'(DIV_LO_K);
  assign q_lo    = lo_prod[DIV_LO_SH +: LO_W];
  assign q_mag   = {d_qhi, q_lo};

  assign res_new.laplacian  = d_neg ? -$signed(q_mag) : $signed(q_mag);
  assign res_new.last_voxel = d_last;

  // ---------------------------------------------------------------- result queue
  assign pop = result.valid && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      res_count <= '0;
    end else begin
      if (d_valid) begin
        wr_ptr <= wr_ptr + RES_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + RES_AW'(1);
      end
      res_count <= res_count + (RES_AW + 1)'(d_valid) - (RES_AW + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (d_valid) begin
      res_mem[wr_ptr] <= res_new;
    end
  end

  assign result.valid      = res_count != '0;
  assign result.laplacian  = res_mem[rd_ptr].laplacian;
  assign result.last_voxel = res_mem[rd_ptr].last_voxel;

endmodule
